// File: rtl/triangle_unit_normal_macros.svh
// ---------------------------------------------------------------------------
// Triangle unit normal assertion macros
// Short forms for the concurrent checks of the triangle unit normal block.
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_MACROS_SVH

`ifndef SYNTHESIS
`define TUN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("triangle_unit_normal: assertion failed");
`define TUN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) \
    else $error("triangle_unit_normal: assertion failed");
`else
`define TUN_ASSERT(lbl, prop)
`define TUN_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/tun_pkg.sv
// ---------------------------------------------------------------------------
// Triangle unit normal package
// Widths, shared types and the step functions of the root and divide units.
// ---------------------------------------------------------------------------
`default_nettype none

package tun_pkg;

  localparam int CoordW     = 32;
  localparam int FieldW     = 32;
  localparam int EdgeW      = CoordW + 1;
  localparam int ProdW      = 2 * EdgeW;
  localparam int CrossW     = ProdW + 1;
  localparam int LenW       = $clog2(CrossW + 1);
  localparam int MagW       = 31;
  localparam int FracW      = 15;
  localparam int SqW        = 2 * MagW;
  localparam int SumW       = SqW + 2;
  localparam int SqrtSteps  = SumW / 2;
  localparam int RootW      = SumW / 2 + 1;
  localparam int QuoW       = FracW + 2;
  localparam int NumW       = MagW + FracW + 1;
  localparam int OutW       = 16;
  localparam int GroupW     = 8;
  localparam int NumGroups  = (CrossW + GroupW - 1) / GroupW;
  localparam int GrpPosW    = $clog2(GroupW);
  localparam int FifoDepth  = 4;
  localparam int FifoPtrW   = $clog2(FifoDepth);
  localparam int FifoCntW   = $clog2(FifoDepth + 1);

  typedef logic signed [EdgeW-1:0] edge_t;

  typedef struct packed {
    edge_t [2:0] a;
    edge_t [2:0] b;
  } edges_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic [2:0]           neg;
    logic                 degen;
  } flags_t;

  typedef struct packed {
    logic [2:0][MagW-1:0] m;
    flags_t               flg;
  } norm_t;

  typedef struct packed {
    logic [SumW-1:0] x;
    logic [SumW-1:0] r;
  } sqrt_t;

  typedef struct packed {
    logic [RootW-1:0] rem;
    logic [QuoW-1:0]  q;
  } div_t;

  // Bit length of one group of the combined magnitude word.
  function automatic logic [GrpPosW:0] grp_len(input logic [GroupW-1:0] g);
    logic [GrpPosW:0] len;
    len = '0;
    for (int i = 0; i < GroupW; i++) begin
      if (g[i]) len = (GrpPosW + 1)'(i + 1);
    end
    return len;
  endfunction

  // One iteration of the digit-by-digit integer square root.
  function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [SumW-1:0] bitv);
    sqrt_t           o;
    logic [SumW-1:0] t;
    t = s.r + bitv;
    if (s.x >= t) begin
      o.x = s.x - t;
      o.r = (s.r >> 1) + bitv;
    end else begin
      o.x = s.x;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  // One restoring division step: brings in one numerator bit.
  function automatic div_t div_step(input div_t d, input logic nbit,
                                    input logic [RootW-1:0] l);
    div_t           o;
    logic [RootW:0] r2;
    r2 = {d.rem, nbit};
    if (r2 >= {1'b0, l}) begin
      r2    = r2 - {1'b0, l};
      o.q   = {d.q[QuoW-2:0], 1'b1};
    end else begin
      o.q   = {d.q[QuoW-2:0], 1'b0};
    end
    o.rem = r2[RootW-1:0];
    return o;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tun_front.sv
// ---------------------------------------------------------------------------
// Triangle unit normal front end
// Takes a triangle word, forms both edge vectors and hands them to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module tun_front import tun_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic [FieldW-1:0] v0_x_i,
  input  logic [FieldW-1:0] v0_y_i,
  input  logic [FieldW-1:0] v0_z_i,
  input  logic [FieldW-1:0] v1_x_i,
  input  logic [FieldW-1:0] v1_y_i,
  input  logic [FieldW-1:0] v1_z_i,
  input  logic [FieldW-1:0] v2_x_i,
  input  logic [FieldW-1:0] v2_y_i,
  input  logic [FieldW-1:0] v2_z_i,
  input  fifo_stat_t        fifo_stat_i,
  output logic              push_o,
  output edges_t            edges_o
);

  function automatic edge_t coord(input logic [FieldW-1:0] raw);
    return EdgeW'($signed(raw[CoordW-1:0]));
  endfunction

  logic   valid_q, valid_d;
  logic   adv;
  edges_t edges_q, edges_d;
  logic [2:0][FieldW-1:0] v0, v1, v2;

  assign v0 = {v0_z_i, v0_y_i, v0_x_i};
  assign v1 = {v1_z_i, v1_y_i, v1_x_i};
  assign v2 = {v2_z_i, v2_y_i, v2_x_i};

  assign adv     = !valid_q || !fifo_stat_i.full;
  assign stall_o = !adv;
  assign push_o  = valid_q && !fifo_stat_i.full;
  assign edges_o = edges_q;

  always_comb begin
    valid_d = valid_q;
    edges_d = edges_q;
    if (adv) begin
      valid_d = valid_i;
      for (int i = 0; i < 3; i++) begin
        edges_d.a[i] = coord(v1[i]) - coord(v0[i]);
        edges_d.b[i] = coord(v2[i]) - coord(v0[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    edges_q <= edges_d;
  end

endmodule

`default_nettype wire

// File: rtl/tun_fifo.sv
// ---------------------------------------------------------------------------
// Triangle unit normal edge queue
// Short queue of edge words between the front end and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module tun_fifo import tun_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  edges_t     data_i,
  input  logic       pop_i,
  output edges_t     data_o,
  output fifo_stat_t stat_o
);

  edges_t               slot_q [FifoDepth];
  logic [FifoPtrW-1:0]  wr_q, rd_q;
  logic [FifoCntW-1:0]  cnt_q;

  assign data_o       = slot_q[rd_q];
  assign stat_o.full  = (cnt_q == FifoCntW'(FifoDepth));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= data_i;
  end

endmodule

`default_nettype wire

// File: rtl/tun_back.sv
// ---------------------------------------------------------------------------
// Triangle unit normal back end
// Cross product, normalization, square root, division and the output word.
// ---------------------------------------------------------------------------
`default_nettype none

module tun_back import tun_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fifo_stat_t             fifo_stat_i,
  input  edges_t                 edges_i,
  output logic                   pop_o,
  output logic                   valid_o,
  input  logic                   stall_i,
  output logic signed [OutW-1:0] normal_x_o,
  output logic signed [OutW-1:0] normal_y_o,
  output logic signed [OutW-1:0] normal_z_o,
  output logic                   degenerate_o
);

  // The whole pipeline moves as one; it only halts when the output word
  // is held by the consumer.
  logic adv;
  logic out_valid_q;

  assign adv   = !out_valid_q || !stall_i;
  assign pop_o = adv && !fifo_stat_i.empty;

  // Products, cross, magnitude, group lengths, bit length, shift, squares.
  logic                               v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic signed [5:0][ProdW-1:0]       prod_q;
  logic signed [2:0][CrossW-1:0]      cross_q;
  logic [2:0][CrossW-1:0]             mag3_q, mag4_q, mag5_q;
  logic [2:0]                         neg3_q, neg4_q, neg5_q;
  logic [GrpPosW:0]                   grp_q [NumGroups];
  logic [LenW-1:0]                    n_q;
  norm_t                              norm6_q, norm7_q;
  logic [2:0][SqW-1:0]                sq_q;

  logic [CrossW-1:0]                  or_mag;
  logic [NumGroups*GroupW-1:0]        or_pad;
  logic [LenW-1:0]                    n_d;
  norm_t                              norm_d;
  logic [CrossW+MagW-1:0]             sh;

  always_comb begin
    or_mag = mag3_q[0] | mag3_q[1] | mag3_q[2];
    or_pad = (NumGroups*GroupW)'(or_mag);
    n_d    = '0;
    for (int g = 0; g < NumGroups; g++) begin
      if (grp_q[g] != '0) n_d = LenW'(g * GroupW) + LenW'(grp_q[g]);
    end
    norm_d.flg.neg   = neg5_q;
    norm_d.flg.degen = (n_q == '0);
    for (int i = 0; i < 3; i++) begin
      sh            = {mag5_q[i], MagW'(0)} >> n_q;
      norm_d.m[i]   = sh[MagW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (adv) begin
      v1_q <= !fifo_stat_i.empty;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q[0] <= edges_i.a[1] * edges_i.b[2];
      prod_q[1] <= edges_i.a[2] * edges_i.b[1];
      prod_q[2] <= edges_i.a[2] * edges_i.b[0];
      prod_q[3] <= edges_i.a[0] * edges_i.b[2];
      prod_q[4] <= edges_i.a[0] * edges_i.b[1];
      prod_q[5] <= edges_i.a[1] * edges_i.b[0];
      for (int i = 0; i < 3; i++) begin
        cross_q[i] <= CrossW'($signed(prod_q[2*i])) - CrossW'($signed(prod_q[2*i+1]));
        neg3_q[i]  <= cross_q[i][CrossW-1];
        mag3_q[i]  <= cross_q[i][CrossW-1] ? CrossW'(-cross_q[i]) : cross_q[i];
        sq_q[i]    <= SqW'(norm6_q.m[i]) * SqW'(norm6_q.m[i]);
      end
      for (int g = 0; g < NumGroups; g++) begin
        grp_q[g] <= grp_len(or_pad[g*GroupW +: GroupW]);
      end
      mag4_q  <= mag3_q;
      neg4_q  <= neg3_q;
      mag5_q  <= mag4_q;
      neg5_q  <= neg4_q;
      n_q     <= n_d;
      norm6_q <= norm_d;
      norm7_q <= norm6_q;
    end
  end

  // Square root: one result bit per stage.
  logic  sv_q   [SqrtSteps+1];
  sqrt_t sr_q   [SqrtSteps+1];
  norm_t snrm_q [SqrtSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (adv) begin
      sv_q[0] <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sr_q[0].x <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
      sr_q[0].r <= '0;
      snrm_q[0] <= norm7_q;
    end
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam logic [SumW-1:0] StepBit = SumW'(1) << (SumW - 2 - 2 * k);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else if (adv) begin
        sv_q[k+1] <= sv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sr_q[k+1]   <= sqrt_step(sr_q[k], StepBit);
        snrm_q[k+1] <= snrm_q[k];
      end
    end
  end

  // Division: one quotient bit per stage, three lanes sharing the length.
  logic             dv_q  [QuoW+1];
  div_t             dd_q  [QuoW+1][3];
  logic [NumW-1:0]  dn_q  [QuoW+1][3];
  logic [RootW-1:0] dl_q  [QuoW+1];
  flags_t           df_q  [QuoW+1];

  logic [RootW-1:0] root;
  logic [NumW-1:0]  num [3];

  assign root = sr_q[SqrtSteps].r[RootW-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = (NumW'(snrm_q[SqrtSteps].m[i]) << FracW) + NumW'(root >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= sv_q[SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dn_q[0][i]     <= num[i];
        dd_q[0][i].rem <= RootW'(num[i] >> QuoW);
        dd_q[0][i].q   <= '0;
      end
      dl_q[0] <= root;
      df_q[0] <= snrm_q[SqrtSteps].flg;
    end
  end

  for (genvar j = 0; j < QuoW; j++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else if (adv) begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          dd_q[j+1][i] <= div_step(dd_q[j][i], dn_q[j][i][QuoW-1-j], dl_q[j]);
          dn_q[j+1][i] <= dn_q[j][i];
        end
        dl_q[j+1] <= dl_q[j];
        df_q[j+1] <= df_q[j];
      end
    end
  end

  // Output word with sign and saturation.
  logic [2:0][OutW-1:0] res_d;
  logic [2:0][OutW-1:0] res_q;
  logic                 degen_q;
  logic [QuoW-1:0]      qv;

  localparam logic [QuoW-1:0] PosMax = QuoW'(2 ** (OutW - 1) - 1);
  localparam logic [QuoW-1:0] NegMax = QuoW'(2 ** (OutW - 1));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qv = dd_q[QuoW][i].q;
      if (df_q[QuoW].degen) begin
        res_d[i] = '0;
      end else if (df_q[QuoW].neg[i]) begin
        if (qv > NegMax) qv = NegMax;
        res_d[i] = OutW'(~qv + 1'b1);
      end else begin
        if (qv > PosMax) qv = PosMax;
        res_d[i] = qv[OutW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_q[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q   <= res_d;
      degen_q <= df_q[QuoW].degen;
    end
  end

  assign valid_o      = out_valid_q;
  assign normal_x_o   = res_q[0];
  assign normal_y_o   = res_q[1];
  assign normal_z_o   = res_q[2];
  assign degenerate_o = degen_q;

endmodule

`default_nettype wire

// File: rtl/triangle_unit_normal.sv
// ---------------------------------------------------------------------------
// Triangle unit normal
// Unit face normal of one triangle per word, in signed Q1.15.
// ---------------------------------------------------------------------------
// The block takes one triangle word per clock and gives one normal word per
// clock at full rate while the output is not stalled. A word passes the
// front register, the queue, the stages for products, cross product,
// magnitude, the two-step bit length search, normalizing shift, squares and
// their sum, the square root (one root bit per stage), the three dividers
// (one quotient bit per stage) and the output register.
// A four-word queue parts the front end from the back end, so the front
// keeps taking words for a while after the output is stalled. A zero cross
// product gives a zero normal with the degenerate flag set.
`default_nettype none

`include "triangle_unit_normal_macros.svh"

module triangle_unit_normal import tun_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic signed [FieldW-1:0] v0_x_i,
  input  logic signed [FieldW-1:0] v0_y_i,
  input  logic signed [FieldW-1:0] v0_z_i,
  input  logic signed [FieldW-1:0] v1_x_i,
  input  logic signed [FieldW-1:0] v1_y_i,
  input  logic signed [FieldW-1:0] v1_z_i,
  input  logic signed [FieldW-1:0] v2_x_i,
  input  logic signed [FieldW-1:0] v2_y_i,
  input  logic signed [FieldW-1:0] v2_z_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic signed [OutW-1:0]   normal_x_o,
  output logic signed [OutW-1:0]   normal_y_o,
  output logic signed [OutW-1:0]   normal_z_o,
  output logic                     degenerate_o
);

  fifo_stat_t fifo_stat;
  logic       fifo_push;
  logic       fifo_pop;
  edges_t     push_data;
  edges_t     pop_data;

  tun_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .v0_x_i      (v0_x_i),
    .v0_y_i      (v0_y_i),
    .v0_z_i      (v0_z_i),
    .v1_x_i      (v1_x_i),
    .v1_y_i      (v1_y_i),
    .v1_z_i      (v1_z_i),
    .v2_x_i      (v2_x_i),
    .v2_y_i      (v2_y_i),
    .v2_z_i      (v2_z_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (fifo_push),
    .edges_o     (push_data)
  );

  tun_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fifo_push),
    .data_i (push_data),
    .pop_i  (fifo_pop),
    .data_o (pop_data),
    .stat_o (fifo_stat)
  );

  tun_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_stat_i  (fifo_stat),
    .edges_i      (pop_data),
    .pop_o        (fifo_pop),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .normal_x_o   (normal_x_o),
    .normal_y_o   (normal_y_o),
    .normal_z_o   (normal_z_o),
    .degenerate_o (degenerate_o)
  );

  // A degenerate word carries a zero normal.
  `TUN_ASSERT(a_degen_zero, (valid_o && degenerate_o) |-> (normal_x_o == 16'sd0 && normal_y_o == 16'sd0 && normal_z_o == 16'sd0))
  // A unit vector has at least one component of magnitude near 1/sqrt(3) or more.
  `TUN_ASSERT(a_unit_len, (valid_o && !degenerate_o) |-> (normal_x_o > 16'sd18000 || normal_x_o < -16'sd18000 || normal_y_o > 16'sd18000 || normal_y_o < -16'sd18000 || normal_z_o > 16'sd18000 || normal_z_o < -16'sd18000))
  // The input only stalls when the queue is full.
  `TUN_ASSERT(a_stall_full, stall_o |-> fifo_stat.full)
  // A pop without a push always frees a slot.
  `TUN_ASSERT_NEXT(a_pop_frees, (fifo_pop && !fifo_push), !fifo_stat.full)

endmodule

`default_nettype wire

// File: bench/triangle_unit_normal_tb.sv
// ---------------------------------------------------------------------------
// Triangle unit normal testbench
// Streams triangles through the block under random idling on both sides and
// checks every normal word against an exact fixed-point normal computed here.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_unit_normal_tb;
  import tun_pkg::*;

  typedef struct {
    logic [31:0] v [9];
  } tri_t;

  typedef struct {
    logic signed [15:0] nx, ny, nz;
    logic               degen;
  } normal_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic stall_o, valid_o, degenerate_o;
  logic signed [31:0] vin [9];
  logic signed [15:0] normal_x_o, normal_y_o, normal_z_o;

  tri_t    pending_tris [$];
  normal_t normals_due [$];
  int      send_idle_pct = 17;
  int      recv_idle_pct = 72;
  int      errors = 0;
  int      checked = 0;
  int      degen_seen = 0;
  longint  cycles = 0;
  logic    stim_done = 1'b0;

  always #1 clk_i = ~clk_i;

  initial for (int i = 0; i < 9; i++) vin[i] = '0;

  triangle_unit_normal dut (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .v0_x_i(vin[0]), .v0_y_i(vin[1]), .v0_z_i(vin[2]),
    .v1_x_i(vin[3]), .v1_y_i(vin[4]), .v1_z_i(vin[5]),
    .v2_x_i(vin[6]), .v2_y_i(vin[7]), .v2_z_i(vin[8]),
    .valid_o, .stall_i,
    .normal_x_o, .normal_y_o, .normal_z_o, .degenerate_o
  );

  // Exact cross product, scaled so the largest magnitude sits in
  // [2^30, 2^31), then divided by the floored root of the sum of squares.
  function automatic normal_t face_normal(tri_t t);
    logic signed [33:0]  ea [3];
    logic signed [33:0]  eb [3];
    logic signed [127:0] cr [3];
    logic [127:0]        mg [3];
    logic [63:0]         m [3];
    logic [63:0]         sum, root, rem, bitv, q;
    int                  nmax;
    normal_t             r;
    for (int i = 0; i < 3; i++) begin
      ea[i] = 34'(signed'(t.v[3+i])) - 34'(signed'(t.v[i]));
      eb[i] = 34'(signed'(t.v[6+i])) - 34'(signed'(t.v[i]));
    end
    cr[0] = 128'(ea[1]) * 128'(eb[2]) - 128'(ea[2]) * 128'(eb[1]);
    cr[1] = 128'(ea[2]) * 128'(eb[0]) - 128'(ea[0]) * 128'(eb[2]);
    cr[2] = 128'(ea[0]) * 128'(eb[1]) - 128'(ea[1]) * 128'(eb[0]);
    nmax = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = cr[i][127] ? -cr[i] : cr[i];
      for (int b = 0; b < 128; b++) if (mg[i][b] && b + 1 > nmax) nmax = b + 1;
    end
    r = '{0, 0, 0, 1'b0};
    if (nmax == 0) begin
      r.degen = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++)
      m[i] = (nmax > 31) ? 64'(mg[i] >> (nmax - 31)) : 64'(mg[i] << (31 - nmax));
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    rem = sum;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    for (int i = 0; i < 3; i++) begin
      logic signed [15:0] o;
      q = ((m[i] << 15) + (root >> 1)) / root;
      if (cr[i][127]) begin
        if (q > 32768) q = 32768;
        o = 16'(-q);
      end else begin
        if (q > 32767) q = 32767;
        o = 16'(q);
      end
      if (i == 0) r.nx = o;
      else if (i == 1) r.ny = o;
      else r.nz = o;
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000)) - 1000);
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
    endcase
  endfunction

  task automatic queue_tri(tri_t t);
    pending_tris = {pending_tris, t};
  endtask

  task automatic add_tri(logic [31:0] a0, a1, a2, b0, b1, b2, c0, c1, c2);
    tri_t t;
    t.v = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
    queue_tri(t);
  endtask

  task automatic add_random_tri();
    tri_t t;
    int   k;
    for (int i = 0; i < 9; i++) t.v[i] = rand_coord();
    k = $urandom_range(0, 9);
    // Collinear or repeated vertices give a zero cross product.
    if (k == 0) for (int i = 0; i < 3; i++) t.v[6+i] = t.v[3+i];
    else if (k == 1) for (int i = 0; i < 3; i++)
      t.v[6+i] = 32'(2 * $signed(t.v[3+i]) - $signed(t.v[i]));
    queue_tri(t);
  endtask

  // Driver: the word stays put while stalled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!valid_i || !stall_o) begin
        if (pending_tris.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          tri_t t;
          t = pending_tris.pop_front();
          normals_due = {normals_due, face_normal(t)};
          for (int i = 0; i < 9; i++) vin[i] <= t.v[i];
          valid_i <= 1'b1;
        end else begin
          valid_i <= 1'b0;
        end
      end
      stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && valid_o && !stall_i) begin
      if (normals_due.size() == 0) begin
        $error("normal word with none expected");
        errors++;
      end else begin
        normal_t e;
        e = normals_due.pop_front();
        checked++;
        if (e.degen) degen_seen++;
        if (normal_x_o !== e.nx) begin
          $error("normal_x expected %0d actual %0d", e.nx, normal_x_o); errors++;
        end
        if (normal_y_o !== e.ny) begin
          $error("normal_y expected %0d actual %0d", e.ny, normal_y_o); errors++;
        end
        if (normal_z_o !== e.nz) begin
          $error("normal_z expected %0d actual %0d", e.nz, normal_z_o); errors++;
        end
        if (degenerate_o !== e.degen) begin
          $error("degenerate expected %0b actual %0b", e.degen, degenerate_o); errors++;
        end
      end
    end
  end

  initial begin
    localparam logic [31:0] MaxC = 32'h7fff_ffff, MinC = 32'h8000_0000;
    localparam logic [31:0] One = 32'h0001_0000;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Axis-aligned faces give exactly one, which must saturate when positive.
    add_tri(0, 0, 0, One, 0, 0, 0, One, 0);
    add_tri(0, 0, 0, 0, One, 0, One, 0, 0);
    add_tri(0, 0, 0, 0, One, 0, 0, 0, One);
    add_tri(0, 0, 0, 0, 0, One, 0, One, 0);
    add_tri(0, 0, 0, 0, 0, One, One, 0, 0);
    add_tri(0, 0, 0, One, 0, 0, 0, 0, One);
    // Degenerate: all equal, and collinear.
    add_tri(5, 6, 7, 5, 6, 7, 5, 6, 7);
    add_tri(0, 0, 0, 1, 2, 3, 2, 4, 6);
    // Extreme coordinates and edge spans.
    add_tri(MinC, MinC, MinC, MaxC, MinC, MinC, MinC, MaxC, MinC);
    add_tri(MaxC, MaxC, MaxC, MinC, MaxC, MaxC, MaxC, MinC, MinC);
    add_tri(MinC, MaxC, MinC, MaxC, MinC, MaxC, MinC, MinC, MaxC);
    add_tri(32'hffff_ffff, 0, 0, 0, 32'hffff_ffff, 0, 0, 0, 32'hffff_ffff);
    add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
    add_tri(0, 0, 0, 1, 1, 0, 1, 0, 1);
    add_tri(MaxC, 0, MinC, 0, MaxC, 0, MinC, MinC, MaxC);
    add_tri(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
            32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff, 0, 32'h1234_5678);
    for (int ph = 0; ph < 3; ph++) begin
      for (int i = 0; i < 500; i++) add_random_tri();
      wait (pending_tris.size() == 0 && normals_due.size() == 0);
      send_idle_pct = (ph == 0) ? 72 : 0;
      recv_idle_pct = (ph == 0) ? 17 : 0;
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    repeat (150) @(posedge clk_i);
    $display("Checked %0d normal words (%0d degenerate) over three idling phases.",
             checked, degen_seen);
    if (errors == 0 && normals_due.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    wait (cycles == 200000);
    $display("end of test: mismatches");
    $finish;
  end
endmodule

// File: triangle_unit_normal.f
+incdir+rtl
rtl/tun_pkg.sv
rtl/tun_front.sv
rtl/tun_fifo.sv
rtl/tun_back.sv
rtl/triangle_unit_normal.sv
bench/triangle_unit_normal_tb.sv
